// ===== hw/rtl/cvh_pkg.sv =====
// Shared types and codes for the convex hull block.
`timescale 1ns / 1ps
package cvh_pkg;

  // Command carried in the input tuser
  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_SCAN  = 2'd2,
    FUNC_READ  = 2'd3
  } cvh_func_t;

  // Result status carried in the output tuser
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_NO_SCAN = 2'd3
  } cvh_status_t;

  // Result of one cross product sign evaluation
  typedef struct packed {
    logic done;
    logic pos;
    logic zero;
  } cvh_turn_t;

endpackage

// ===== hw/rtl/cvh_cross.sv =====
// Shared cross product sign unit: one multiplier used twice, then one compare.
`timescale 1ns / 1ps
module cvh_cross #(
  parameter int DW = 17
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic signed [DW-1:0] a,
  input  logic signed [DW-1:0] b,
  input  logic signed [DW-1:0] c,
  input  logic signed [DW-1:0] d,
  output cvh_pkg::cvh_turn_t   res
);
  import cvh_pkg::*;

  localparam int PW = 2 * DW;

  typedef enum logic [1:0] {S_IDLE, S_M1, S_M2, S_CMP} xstate_t;

  xstate_t state;
  logic signed [DW-1:0] ra, rb, rc, rd;
  logic signed [PW-1:0] p1, p2;
  logic signed [DW-1:0] ma, mb;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   diff;

  // Route the operand pair for this phase to the single multiplier
  always_comb begin
    ma = (state == S_M1) ? ra : rc;
    mb = (state == S_M1) ? rb : rd;
    prod = ma * mb;
    diff = (PW + 1)'(p1) - (PW + 1)'(p2);
  end

  // Sequence: capture, a*b, c*d, sign of the difference
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res <= '0;
    end else begin
      res.done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            ra <= a;
            rb <= b;
            rc <= c;
            rd <= d;
            state <= S_M1;
          end
        end
        S_M1: begin
          p1 <= prod;
          state <= S_M2;
        end
        S_M2: begin
          p2 <= prod;
          state <= S_CMP;
        end
        S_CMP: begin
          res.done <= 1'b1;
          res.pos <= (diff > 0);
          res.zero <= (diff == 0);
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_cmp: assert property (@(posedge clk) disable iff (rst)
    res.done |-> $past(state) == S_CMP)
    else $error("turn result without a compare phase");
  a_pos_zero_excl: assert property (@(posedge clk) disable iff (rst)
    res.done |-> !(res.pos && res.zero))
    else $error("turn both positive and zero");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && start) |=> state == S_M1)
    else $error("start not taken");
`endif

endmodule

// ===== hw/rtl/convex_hull_graham_scan.sv =====
// Top level: point store, hull stack and the scan sequencer.
//
//  channel | dir | handshake            | content
//  s_axis  | in  | s_tvalid / s_tready  | tuser func, tdata px, py, vertex_index
//  m_axis  | out | m_tvalid / m_tready  | tuser status, tdata hull_x, hull_y, hull_count
//
// Clear and add answer straight from idle. A read goes through stack memory,
// then point memory, both with registered reads. A scan runs the pivot search
// over all points, the pivot swap (SWAP0 to SWAP2), an insertion sort by angle
// with one turn check per compare (the shared cross product unit captures, forms
// two products, then compares), and a stack pass with turn checks and pop refetches.
// Reset is synchronous and clears counts and scan state; memories are left.
// The block takes a new word only when idle and the output register is free
// or being drained in that cycle.
`timescale 1ns / 1ps
module convex_hull_graham_scan #(
  parameter int MAX_POINTS  = 128,
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // px[15:0], py[31:16], vertex_index[38:32], zero
  input  logic [1:0]  s_tuser,   // func[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // hull_x[15:0], hull_y[31:16], hull_count[39:32]
  output logic [1:0]  m_tuser    // status[1:0]
);
  import cvh_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int AW   = $clog2(MAX_POINTS);
  localparam int CNTW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    IDLE, PIV0, PIV_LOOP, SWAP0, SWAP1, SWAP2,
    SORT_RD, SORT_KEY, SORT_RDJ, SORT_CMP, SORT_GO, SORT_WAIT, SORT_PUT,
    STK_RD, STK_GOT, STK_CHK, STK_WAIT, STK_POP_S, STK_POP_P, STK_POP_G, STK_PUSH,
    FIN, RD_S, RD_P, RD_G
  } state_t;

  state_t state;
  logic [CNTW-1:0] cnt, depth, i, j;
  logic            svalid;
  logic [AW-1:0]   bidx;
  logic [6:0]      idx;
  logic signed [CW-1:0] bx, by, kx, ky, sx, sy, t1x, t1y, t2x, t2y;

  // Input decode
  logic        acc;
  cvh_func_t   func;
  logic [31:0] ext_x, ext_y;
  logic signed [CW-1:0] in_x, in_y;
  assign acc   = s_tvalid && s_tready;
  assign func  = cvh_func_t'(s_tuser);
  assign ext_x = {16'b0, s_tdata[15:0]};
  assign ext_y = {16'b0, s_tdata[31:16]};
  assign in_x  = ext_x[CW-1:0];
  assign in_y  = ext_y[CW-1:0];
  assign s_tready = (state == IDLE) && (!m_tvalid || m_tready);

  // Output register
  logic [15:0] hx, hy;
  logic [7:0]  hc;
  cvh_status_t st;
  assign m_tdata = {hc, hy, hx};
  assign m_tuser = st;

  // Point memory
  logic signed [CW-1:0] mem_x [MAX_POINTS];
  logic signed [CW-1:0] mem_y [MAX_POINTS];
  logic [AW-1:0]        pa, pwa;
  logic                 pwe;
  logic signed [CW-1:0] pwx, pwy, prx, pry;

  // Hull stack memory
  logic [AW-1:0] stk [MAX_POINTS];
  logic [AW-1:0] sa, swa, swd, srd;
  logic          swe;

  always_ff @(posedge clk) begin
    if (pwe) begin
      mem_x[pwa] <= pwx;
      mem_y[pwa] <= pwy;
    end
    prx <= mem_x[pa];
    pry <= mem_y[pa];
  end

  always_ff @(posedge clk) begin
    if (swe) stk[swa] <= swd;
    srd <= stk[sa];
  end

  // Shared turn unit
  logic                 xstart;
  logic signed [DW-1:0] xa, xb, xc, xd;
  cvh_turn_t            xr;

  cvh_cross #(.DW(DW)) u_cross (
    .clk(clk), .rst(rst), .start(xstart),
    .a(xa), .b(xb), .c(xc), .d(xd), .res(xr)
  );

  logic [CNTW-1:0] i1, jm1;
  logic            key_ahead;
  logic [31:0]     rd_x, rd_y;
  assign i1  = i + CNTW'(1);
  assign jm1 = j - CNTW'(1);
  assign key_ahead = xr.pos || (xr.zero && (kx < sx || (kx == sx && ky < sy)));
  assign rd_x = 32'({1'b0, prx});
  assign rd_y = 32'({1'b0, pry});

  // Memory addresses, writes and turn operands for the current step
  always_comb begin
    pa = '0; pwe = 1'b0; pwa = '0; pwx = '0; pwy = '0;
    sa = '0; swe = 1'b0; swa = '0; swd = '0;
    xstart = 1'b0; xa = '0; xb = '0; xc = '0; xd = '0;
    case (state)
      IDLE: begin
        if (acc && func == FUNC_ADD && 32'(cnt) < 32'(MAX_POINTS)) begin
          pwe = 1'b1; pwa = cnt[AW-1:0]; pwx = in_x; pwy = in_y;
        end
      end
      PIV0:      pa = i[AW-1:0];
      PIV_LOOP:  pa = i1[AW-1:0];
      SWAP1: begin
        pwe = 1'b1; pwa = bidx; pwx = prx; pwy = pry;
      end
      SWAP2: begin
        pwe = 1'b1; pwa = '0; pwx = bx; pwy = by;
      end
      SORT_RD:   pa = i[AW-1:0];
      SORT_RDJ:  pa = jm1[AW-1:0];
      SORT_GO: begin
        xstart = 1'b1;
        xa = DW'(kx) - DW'(bx); xb = DW'(sy) - DW'(by);
        xc = DW'(ky) - DW'(by); xd = DW'(sx) - DW'(bx);
      end
      SORT_WAIT: begin
        if (xr.done && key_ahead) begin
          pwe = 1'b1; pwa = j[AW-1:0]; pwx = sx; pwy = sy;
        end
      end
      SORT_PUT: begin
        pwe = 1'b1; pwa = j[AW-1:0]; pwx = kx; pwy = ky;
      end
      STK_RD:    pa = i[AW-1:0];
      STK_CHK: begin
        xstart = 1'b1;
        xa = DW'(t1x) - DW'(t2x); xb = DW'(ky) - DW'(t2y);
        xc = DW'(t1y) - DW'(t2y); xd = DW'(kx) - DW'(t2x);
      end
      STK_POP_S: sa = depth[AW-1:0] - AW'(2);
      STK_POP_P: pa = srd;
      STK_PUSH: begin
        swe = 1'b1; swa = depth[AW-1:0]; swd = i[AW-1:0];
      end
      RD_S:      sa = AW'(idx);
      RD_P:      pa = srd;
      default: ;
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      depth <= '0;
      svalid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      case (state)
        IDLE: begin
          if (acc) begin
            hx <= '0;
            hy <= '0;
            st <= ST_OK;
            case (func)
              FUNC_CLEAR: begin
                cnt <= '0;
                depth <= '0;
                svalid <= 1'b0;
                hc <= '0;
                m_tvalid <= 1'b1;
              end
              FUNC_ADD: begin
                if (32'(cnt) >= 32'(MAX_POINTS)) begin
                  st <= ST_FULL;
                end else begin
                  cnt <= cnt + CNTW'(1);
                end
                hc <= svalid ? 8'(depth) : 8'd0;
                m_tvalid <= 1'b1;
              end
              FUNC_SCAN: begin
                depth <= '0;
                svalid <= 1'b1;
                i <= CNTW'(1);
                if (cnt == '0) begin
                  hc <= '0;
                  m_tvalid <= 1'b1;
                end else begin
                  state <= PIV0;
                end
              end
              FUNC_READ: begin
                idx <= s_tdata[38:32];
                if (!svalid) begin
                  st <= ST_NO_SCAN;
                  hc <= '0;
                  m_tvalid <= 1'b1;
                end else if (32'(s_tdata[38:32]) >= 32'(depth)) begin
                  st <= ST_RANGE;
                  hc <= 8'(depth);
                  m_tvalid <= 1'b1;
                end else begin
                  state <= RD_S;
                end
              end
              default: ;
            endcase
          end
        end
        // Pivot search: least x, then least y
        PIV0: begin
          bx <= prx;
          by <= pry;
          bidx <= '0;
          state <= (cnt == CNTW'(1)) ? SWAP0 : PIV_LOOP;
        end
        PIV_LOOP: begin
          if (prx < bx || (prx == bx && pry < by)) begin
            bx <= prx;
            by <= pry;
            bidx <= i[AW-1:0];
          end
          i <= i1;
          if (i1 == cnt) state <= SWAP0;
        end
        SWAP0: state <= SWAP1;
        SWAP1: state <= SWAP2;
        SWAP2: begin
          if (32'(cnt) <= 32'd2) begin
            i <= '0;
            state <= STK_RD;
          end else begin
            i <= CNTW'(2);
            state <= SORT_RD;
          end
        end
        // Insertion sort by angle about the pivot
        SORT_RD: state <= SORT_KEY;
        SORT_KEY: begin
          kx <= prx;
          ky <= pry;
          j <= i;
          state <= SORT_RDJ;
        end
        SORT_RDJ: state <= SORT_CMP;
        SORT_CMP: begin
          sx <= prx;
          sy <= pry;
          state <= SORT_GO;
        end
        SORT_GO: state <= SORT_WAIT;
        SORT_WAIT: begin
          if (xr.done) begin
            if (key_ahead) begin
              j <= jm1;
              state <= (32'(jm1) > 32'd1) ? SORT_RDJ : SORT_PUT;
            end else begin
              state <= SORT_PUT;
            end
          end
        end
        SORT_PUT: begin
          i <= i1;
          if (i1 == cnt) begin
            i <= '0;
            state <= STK_RD;
          end else begin
            state <= SORT_RD;
          end
        end
        // Stack pass: pop while the turn is not strictly counter-clockwise
        STK_RD: state <= STK_GOT;
        STK_GOT: begin
          kx <= prx;
          ky <= pry;
          state <= (32'(depth) >= 32'd2) ? STK_CHK : STK_PUSH;
        end
        STK_CHK: state <= STK_WAIT;
        STK_WAIT: begin
          if (xr.done) begin
            if (!xr.pos) begin
              depth <= depth - CNTW'(1);
              t1x <= t2x;
              t1y <= t2y;
              state <= (32'(depth) >= 32'd3) ? STK_POP_S : STK_PUSH;
            end else begin
              state <= STK_PUSH;
            end
          end
        end
        STK_POP_S: state <= STK_POP_P;
        STK_POP_P: state <= STK_POP_G;
        STK_POP_G: begin
          t2x <= prx;
          t2y <= pry;
          state <= STK_CHK;
        end
        STK_PUSH: begin
          t2x <= t1x;
          t2y <= t1y;
          t1x <= kx;
          t1y <= ky;
          depth <= depth + CNTW'(1);
          i <= i1;
          state <= (i1 == cnt) ? FIN : STK_RD;
        end
        FIN: begin
          hc <= 8'(depth);
          m_tvalid <= 1'b1;
          state <= IDLE;
        end
        // Hull vertex read: stack entry, then point
        RD_S: state <= RD_P;
        RD_P: state <= RD_G;
        RD_G: begin
          hx <= rd_x[15:0];
          hy <= rd_y[15:0];
          hc <= 8'(depth);
          m_tvalid <= 1'b1;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= 32'(MAX_POINTS) && depth <= cnt)
    else $error("point count or stack depth out of range");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == IDLE)
    else $error("ready outside idle");
  a_turn_in_wait: assert property (@(posedge clk) disable iff (rst)
    xr.done |-> (state == SORT_WAIT || state == STK_WAIT))
    else $error("turn result outside a wait step");
  a_scan_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (acc && func == FUNC_SCAN) |=> svalid)
    else $error("scan did not mark hull valid");
`endif

endmodule
